>>> hdl/bwrm_pkg.sv
// ----------------------------------------------------------------------------
// bwrm_pkg
// Shared types and constants of the binned window event rate meter.
// ----------------------------------------------------------------------------
package bwrm_pkg;

  // Ring geometry and field widths.
  localparam int MAX_BINS   = 1024;
  localparam int BIN_IDX_W  = $clog2(MAX_BINS);
  localparam int FILL_W     = $clog2(MAX_BINS + 1);
  localparam int BIN_CNT_W  = 16;
  localparam int AGE_W      = 16;
  localparam int MS_W       = 16;
  localparam int SUM_W      = 27;
  localparam int WIN_W      = 26;
  localparam int RATE_W     = 45;
  localparam int SCALE_W    = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Counts per ms to counts per second, with eight fraction bits.
  localparam logic [SCALE_W-1:0] RATE_SCALE = 18'd256000;

  // Serial divider: one quotient bit per step.
  localparam int DIV_STEPS = RATE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Register reset values.
  localparam logic [FILL_W-1:0] BINS_IN_USE_RST = 11'd60;
  localparam logic [MS_W-1:0]   BIN_LENGTH_RST  = 16'd1000;
  localparam logic [MS_W-1:0]   EVENT_DEAD_RST  = 16'd30;
  localparam logic [MS_W-1:0]   SAMPLE_DEAD_RST = 16'd10;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_AND_EVENT = 2'd1,
    CMD_XOR_EVENT = 2'd2,
    CMD_QUERY     = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BINS_IN_USE = 2'd0,
    CFG_BIN_LENGTH  = 2'd1,
    CFG_EVENT_DEAD  = 2'd2,
    CFG_SAMPLE_DEAD = 2'd3
  } cfg_idx_t;

  // Rate selection codes of a query.
  localparam logic [1:0] SEL_XOR  = 2'd0;
  localparam logic [1:0] SEL_AND  = 2'd1;
  localparam logic [1:0] SEL_BOTH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROLL,
    ST_START,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hdl/bwrm_in_if.sv
// ----------------------------------------------------------------------------
// bwrm_in_if
// Command channel of the rate meter: valid/ready handshake and one command.
// ----------------------------------------------------------------------------
interface bwrm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [1:0] which_rate;

  modport source (output valid, output cmd, output which_rate, input ready);
  modport sink   (input valid, input cmd, input which_rate, output ready);
endinterface

>>> hdl/bwrm_out_if.sv
// ----------------------------------------------------------------------------
// bwrm_out_if
// Result channel of the rate meter: valid/ready handshake and one result.
// ----------------------------------------------------------------------------
interface bwrm_out_if;
  logic                           valid;
  logic                           ready;
  logic                           forward_event;
  logic                           sample_trigger;
  logic [bwrm_pkg::SUM_W-1:0]     count_sum;
  logic [bwrm_pkg::WIN_W-1:0]     window_ms;
  logic [bwrm_pkg::RATE_W-1:0]    rate_q8;
  logic                           rate_valid;

  modport source (output valid, output forward_event, output sample_trigger,
                  output count_sum, output window_ms, output rate_q8,
                  output rate_valid, input ready);
  modport sink   (input valid, input forward_event, input sample_trigger,
                  input count_sum, input window_ms, input rate_q8,
                  input rate_valid, output ready);
endinterface

>>> hdl/binned_window_event_rate_meter.sv
// ----------------------------------------------------------------------------
// binned_window_event_rate_meter
// Sliding-window coincidence and anticoincidence rate meter over time bins.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on in_ch carries one command: a millisecond tick, an AND event,
// an XOR event or a rate query. Every accepted beat yields exactly one result
// beat on out_ch. Ticks return all-zero results, events return the forward
// and sampling flags, and queries return the window count, the window length
// in ms and the rate in counts per second with eight fraction bits.
// For ticks and events the result is registered at the accepting edge. A
// tick that rolls a full ring of more than one bin reads the oldest bin back
// from the bin RAM and passes through the rollover state, which subtracts it,
// before the next beat is taken. A query registers the selected sum and the
// window length, starts the serial divider on the scaled dividend, runs its
// 45 steps and loads the result register once that register is free.
// The output register decouples the channels: a new beat is taken while a
// finished result still waits, as long as the result register will be free
// at that edge. A stalled receiver holds the result steady and back-pressures
// in_ch. Synchronous reset restores the register defaults and an empty window
// with one zero bin; writing bins_in_use or bin_length_ms on the cfg port
// does the same to the counts. The bin RAM itself needs no clearing pass.
// ----------------------------------------------------------------------------
module binned_window_event_rate_meter (
  input  logic                               clk,
  input  logic                               rst_n,
  bwrm_in_if.sink                            in_ch,
  bwrm_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [bwrm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bwrm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int RAM_W = 2 * bwrm_pkg::BIN_CNT_W;
  localparam int PAD_W = bwrm_pkg::SUM_W - bwrm_pkg::BIN_CNT_W;

  // Configuration registers.
  logic [bwrm_pkg::FILL_W-1:0]    bins_in_use_r;
  logic [bwrm_pkg::MS_W-1:0]      bin_len_r;
  logic [bwrm_pkg::MS_W-1:0]      event_dead_r;
  logic [bwrm_pkg::MS_W-1:0]      sample_dead_r;

  // Window state. The newest bin lives in registers; older bins in the RAM.
  logic [bwrm_pkg::BIN_IDX_W-1:0] newest_r;
  logic [bwrm_pkg::FILL_W-1:0]    filled_r;
  logic [bwrm_pkg::MS_W-1:0]      elapsed_r;
  logic [bwrm_pkg::SUM_W-1:0]     and_sum_r;
  logic [bwrm_pkg::SUM_W-1:0]     xor_sum_r;
  logic [bwrm_pkg::BIN_CNT_W-1:0] cur_and_r;
  logic [bwrm_pkg::BIN_CNT_W-1:0] cur_xor_r;
  logic [bwrm_pkg::AGE_W-1:0]     and_age_r;
  logic [bwrm_pkg::AGE_W-1:0]     xor_age_r;
  logic [bwrm_pkg::AGE_W-1:0]     sample_age_r;

  // Query and control.
  bwrm_pkg::state_t               state_r;
  bwrm_pkg::state_t               state_nxt;
  logic [bwrm_pkg::SUM_W-1:0]     q_sum_r;
  logic [bwrm_pkg::WIN_W-1:0]     q_win_r;

  // Result register.
  logic                           out_valid_r;
  logic                           out_fwd_r;
  logic                           out_trig_r;
  logic [bwrm_pkg::SUM_W-1:0]     out_sum_r;
  logic [bwrm_pkg::WIN_W-1:0]     out_win_r;
  logic [bwrm_pkg::RATE_W-1:0]    out_rate_r;
  logic                           out_rvalid_r;

  logic                           in_ready;
  logic                           in_fire;
  logic                           out_free;
  logic                           load_query;
  bwrm_pkg::cmd_t                 cmd;

  logic [bwrm_pkg::FILL_W-1:0]    cap_eff;
  logic [bwrm_pkg::MS_W-1:0]      len_eff;
  logic [bwrm_pkg::MS_W:0]        elapsed_inc;
  logic [bwrm_pkg::MS_W:0]        elapsed_wrap;
  logic                           roll;
  logic                           ring_full;
  logic                           single_bin;
  logic [bwrm_pkg::FILL_W-1:0]    back;
  logic [bwrm_pkg::BIN_IDX_W-1:0] old_idx;
  logic                           is_tick;
  logic                           ram_we;
  logic                           ram_re;
  logic [RAM_W-1:0]               ram_rd;

  logic [bwrm_pkg::SUM_W:0]       sel_sum;
  logic [bwrm_pkg::SUM_W-1:0]     sel_sum_sat;
  logic [bwrm_pkg::FILL_W+bwrm_pkg::MS_W-1:0] win_mul;
  logic [bwrm_pkg::FILL_W+bwrm_pkg::MS_W:0]   win_full;
  logic [bwrm_pkg::WIN_W-1:0]     win_sat;

  logic [bwrm_pkg::RATE_W-1:0]    dividend;
  logic [bwrm_pkg::RATE_W-1:0]    quotient;
  bwrm_pkg::div_ctrl_t            div_ctrl;
  bwrm_pkg::div_stat_t            div_stat;

  assign cmd      = bwrm_pkg::cmd_t'(in_ch.cmd);
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_fire  = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // Out-of-range settings: zero bins or zero length act as one, and more
  // bins than the ring holds act as a full ring.
  always_comb begin
    priority if (bins_in_use_r == '0) begin
      cap_eff = bwrm_pkg::FILL_W'(1);
    end else if (bins_in_use_r > bwrm_pkg::FILL_W'(bwrm_pkg::MAX_BINS)) begin
      cap_eff = bwrm_pkg::FILL_W'(bwrm_pkg::MAX_BINS);
    end else begin
      cap_eff = bins_in_use_r;
    end
  end

  assign len_eff = (bin_len_r == '0) ? bwrm_pkg::MS_W'(1) : bin_len_r;

  // Tick arithmetic and bin rollover decision.
  assign elapsed_inc  = {1'b0, elapsed_r} + 1'b1;
  assign elapsed_wrap = elapsed_inc - {1'b0, len_eff};
  assign roll         = elapsed_inc > {1'b0, len_eff};
  assign ring_full    = filled_r >= cap_eff;
  assign single_bin   = filled_r == bwrm_pkg::FILL_W'(1);
  assign back         = filled_r - 1'b1;
  assign old_idx      = newest_r - back[bwrm_pkg::BIN_IDX_W-1:0];
  assign is_tick      = in_fire && (cmd == bwrm_pkg::CMD_TICK);

  // On rollover the finished newest bin is written to the RAM; when the ring
  // is full and holds more than one bin, the oldest bin is read back at the
  // same time and subtracted from the sums in the following cycle.
  assign ram_we = is_tick && roll;
  assign ram_re = is_tick && roll && ring_full && !single_bin;

  bwrm_bin_ram #(
    .DEPTH (bwrm_pkg::MAX_BINS),
    .WIDTH (RAM_W)
  ) u_bin_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (newest_r),
    .wr_data ({cur_and_r, cur_xor_r}),
    .rd_en   (ram_re),
    .rd_addr (old_idx),
    .rd_data (ram_rd)
  );

  // Query operands: the selected window count and the window length.
  always_comb begin
    unique case (in_ch.which_rate)
      bwrm_pkg::SEL_XOR:  sel_sum = {1'b0, xor_sum_r};
      bwrm_pkg::SEL_AND:  sel_sum = {1'b0, and_sum_r};
      bwrm_pkg::SEL_BOTH: sel_sum = {1'b0, xor_sum_r} + {1'b0, and_sum_r};
      default:            sel_sum = '0;
    endcase
  end

  assign sel_sum_sat = sel_sum[bwrm_pkg::SUM_W] ? '1 : sel_sum[bwrm_pkg::SUM_W-1:0];
  assign win_mul     = back * len_eff;
  assign win_full    = {1'b0, win_mul} + (bwrm_pkg::FILL_W + bwrm_pkg::MS_W + 1)'(elapsed_r);
  assign win_sat     = (win_full[bwrm_pkg::FILL_W+bwrm_pkg::MS_W:bwrm_pkg::WIN_W] != '0) ?
                       '1 : win_full[bwrm_pkg::WIN_W-1:0];

  // Scaled dividend, registered inside the divider at start.
  assign dividend = q_sum_r * bwrm_pkg::RATE_SCALE;

  bwrm_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (dividend),
    .divisor  (q_win_r),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bwrm_pkg::ST_IDLE: begin
        if (in_fire) begin
          priority if (cmd == bwrm_pkg::CMD_QUERY) begin
            state_nxt = bwrm_pkg::ST_START;
          end else if (ram_re) begin
            state_nxt = bwrm_pkg::ST_ROLL;
          end else begin
            state_nxt = bwrm_pkg::ST_IDLE;
          end
        end
      end
      bwrm_pkg::ST_ROLL:  state_nxt = bwrm_pkg::ST_IDLE;
      bwrm_pkg::ST_START: state_nxt = bwrm_pkg::ST_DIV;
      bwrm_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = bwrm_pkg::ST_DONE;
        end
      end
      bwrm_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = bwrm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bwrm_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready       = 1'b0;
    div_ctrl.start = 1'b0;
    load_query     = 1'b0;
    unique case (state_r)
      bwrm_pkg::ST_IDLE:  in_ready       = out_free;
      bwrm_pkg::ST_ROLL:  in_ready       = 1'b0;
      bwrm_pkg::ST_START: div_ctrl.start = 1'b1;
      bwrm_pkg::ST_DIV:   in_ready       = 1'b0;
      bwrm_pkg::ST_DONE:  load_query     = out_free;
      default:            in_ready       = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bwrm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration, window state and dead-time ages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_in_use_r <= bwrm_pkg::BINS_IN_USE_RST;
      bin_len_r     <= bwrm_pkg::BIN_LENGTH_RST;
      event_dead_r  <= bwrm_pkg::EVENT_DEAD_RST;
      sample_dead_r <= bwrm_pkg::SAMPLE_DEAD_RST;
      newest_r      <= '0;
      filled_r      <= bwrm_pkg::FILL_W'(1);
      elapsed_r     <= '0;
      and_sum_r     <= '0;
      xor_sum_r     <= '0;
      cur_and_r     <= '0;
      cur_xor_r     <= '0;
      and_age_r     <= '0;
      xor_age_r     <= '0;
      sample_age_r  <= '0;
    end else if (cfg_we) begin
      unique case (bwrm_pkg::cfg_idx_t'(cfg_index))
        bwrm_pkg::CFG_BINS_IN_USE: bins_in_use_r <= cfg_data[bwrm_pkg::FILL_W-1:0];
        bwrm_pkg::CFG_BIN_LENGTH:  bin_len_r     <= cfg_data;
        bwrm_pkg::CFG_EVENT_DEAD:  event_dead_r  <= cfg_data;
        bwrm_pkg::CFG_SAMPLE_DEAD: sample_dead_r <= cfg_data;
        default:                   event_dead_r  <= event_dead_r;
      endcase
      // A new window geometry starts over with one empty bin.
      if (bwrm_pkg::cfg_idx_t'(cfg_index) == bwrm_pkg::CFG_BINS_IN_USE ||
          bwrm_pkg::cfg_idx_t'(cfg_index) == bwrm_pkg::CFG_BIN_LENGTH) begin
        newest_r  <= '0;
        filled_r  <= bwrm_pkg::FILL_W'(1);
        elapsed_r <= '0;
        and_sum_r <= '0;
        xor_sum_r <= '0;
        cur_and_r <= '0;
        cur_xor_r <= '0;
      end
    end else if (state_r == bwrm_pkg::ST_ROLL) begin
      // Drop the oldest bin that the rollover read back.
      and_sum_r <= and_sum_r - {{PAD_W{1'b0}}, ram_rd[RAM_W-1:bwrm_pkg::BIN_CNT_W]};
      xor_sum_r <= xor_sum_r - {{PAD_W{1'b0}}, ram_rd[bwrm_pkg::BIN_CNT_W-1:0]};
    end else if (in_fire) begin
      unique case (cmd)
        bwrm_pkg::CMD_TICK: begin
          if (and_age_r != '1) and_age_r <= and_age_r + 1'b1;
          if (xor_age_r != '1) xor_age_r <= xor_age_r + 1'b1;
          if (sample_age_r != '1) sample_age_r <= sample_age_r + 1'b1;
          if (roll) begin
            elapsed_r <= elapsed_wrap[bwrm_pkg::MS_W-1:0];
            newest_r  <= newest_r + 1'b1;
            cur_and_r <= '0;
            cur_xor_r <= '0;
            if (!ring_full) begin
              filled_r <= filled_r + 1'b1;
            end else if (single_bin) begin
              // A one-bin window drops the bin that is closing right now.
              and_sum_r <= and_sum_r - {{PAD_W{1'b0}}, cur_and_r};
              xor_sum_r <= xor_sum_r - {{PAD_W{1'b0}}, cur_xor_r};
            end
          end else begin
            elapsed_r <= elapsed_inc[bwrm_pkg::MS_W-1:0];
          end
        end
        bwrm_pkg::CMD_AND_EVENT: begin
          if (sample_age_r >= sample_dead_r) sample_age_r <= '0;
          if (and_age_r >= event_dead_r) and_age_r <= '0;
          if (cur_and_r != '1) begin
            cur_and_r <= cur_and_r + 1'b1;
            and_sum_r <= and_sum_r + 1'b1;
          end
        end
        bwrm_pkg::CMD_XOR_EVENT: begin
          if (sample_age_r >= sample_dead_r) sample_age_r <= '0;
          if (xor_age_r >= event_dead_r) xor_age_r <= '0;
          if (cur_xor_r != '1) begin
            cur_xor_r <= cur_xor_r + 1'b1;
            xor_sum_r <= xor_sum_r + 1'b1;
          end
        end
        bwrm_pkg::CMD_QUERY: begin
          newest_r <= newest_r;
        end
        default: begin
          newest_r <= newest_r;
        end
      endcase
    end
  end

  // Query operand capture.
  always_ff @(posedge clk) begin
    if (in_fire && cmd == bwrm_pkg::CMD_QUERY) begin
      q_sum_r <= sel_sum_sat;
      q_win_r <= win_sat;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((in_fire && cmd != bwrm_pkg::CMD_QUERY) || load_query) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_query) begin
      out_fwd_r    <= 1'b0;
      out_trig_r   <= 1'b0;
      out_sum_r    <= q_sum_r;
      out_win_r    <= q_win_r;
      out_rate_r   <= (q_win_r == '0) ? '0 : quotient;
      out_rvalid_r <= (q_win_r != '0);
    end else if (in_fire && cmd != bwrm_pkg::CMD_QUERY) begin
      out_sum_r    <= '0;
      out_win_r    <= '0;
      out_rate_r   <= '0;
      out_rvalid_r <= 1'b0;
      if (cmd == bwrm_pkg::CMD_TICK) begin
        out_fwd_r  <= 1'b0;
        out_trig_r <= 1'b0;
      end else begin
        out_trig_r <= sample_age_r >= sample_dead_r;
        out_fwd_r  <= (cmd == bwrm_pkg::CMD_AND_EVENT) ? (and_age_r >= event_dead_r)
                                                       : (xor_age_r >= event_dead_r);
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.forward_event  = out_fwd_r;
  assign out_ch.sample_trigger = out_trig_r;
  assign out_ch.count_sum      = out_sum_r;
  assign out_ch.window_ms      = out_win_r;
  assign out_ch.rate_q8        = out_rate_r;
  assign out_ch.rate_valid     = out_rvalid_r;

`ifndef SYNTHESIS
  // The ring never holds more bins than the effective window allows.
  a_filled_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (filled_r != '0) && (filled_r <= cap_eff))
    else $error("bins filled outside 1..bins in use");

  // The newest bin never runs longer than one bin length.
  a_elapsed_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    elapsed_r <= len_eff)
    else $error("bin elapsed time exceeds bin length");

  // The oldest-bin read cycle only follows an accepted tick.
  a_roll_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bwrm_pkg::ST_ROLL) |-> $past(is_tick))
    else $error("rollover read without a tick");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == bwrm_pkg::ST_DIV))
    else $error("divider finished outside the divide state");
`endif

endmodule

>>> hdl/bwrm_bin_ram.sv
// ----------------------------------------------------------------------------
// bwrm_bin_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bwrm_bin_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/bwrm_divider.sv
// ----------------------------------------------------------------------------
// bwrm_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bwrm_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bwrm_pkg::div_ctrl_t            ctrl,
  input  logic [bwrm_pkg::RATE_W-1:0]    dividend,
  input  logic [bwrm_pkg::WIN_W-1:0]     divisor,
  output bwrm_pkg::div_stat_t            stat,
  output logic [bwrm_pkg::RATE_W-1:0]    quotient
);

  localparam logic [bwrm_pkg::DIV_CNT_W-1:0] LAST_STEP =
    bwrm_pkg::DIV_CNT_W'(bwrm_pkg::DIV_STEPS - 1);

  logic                           busy_r;
  logic                           done_r;
  logic [bwrm_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [bwrm_pkg::WIN_W-1:0]     div_r;
  logic [bwrm_pkg::WIN_W-1:0]     rem_r;
  logic [bwrm_pkg::RATE_W-1:0]    quo_r;

  logic [bwrm_pkg::WIN_W:0]       shifted;
  logic [bwrm_pkg::WIN_W:0]       diff;
  logic                           ge;
  logic [bwrm_pkg::WIN_W-1:0]     rem_nxt;

  // The quotient register also holds the dividend bits not yet shifted in.
  assign shifted = {rem_r, quo_r[bwrm_pkg::RATE_W-1]};
  assign diff    = shifted - {1'b0, div_r};
  assign ge      = (shifted >= {1'b0, div_r});
  assign rem_nxt = ge ? diff[bwrm_pkg::WIN_W-1:0] : shifted[bwrm_pkg::WIN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      div_r <= divisor;
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[bwrm_pkg::RATE_W-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule
